// File: design/pac_pkg.sv
// shared types, constants and helpers of the pointer acceleration curve
`timescale 1ns / 1ps
package pac_pkg;

   // delta and register widths
   localparam int DELTA_W  = 16;
   localparam int MAG_W    = DELTA_W + 1;
   localparam int SENS_W   = 16;
   localparam int THR_W    = 24;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 24;

   // square root: radicand is (x*x + y*y) << 16
   localparam int SQ_W     = 2 * DELTA_W;
   localparam int RAD_W    = 48;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SQ_REM_W = ROOT_W + 3;

   // divider: quotient bits, denominator and remainder widths
   localparam int QUO_W    = 16;
   localparam int DEN_W    = THR_W + 1;
   localparam int DIV_REM_W = DEN_W + 1;

   // gain in Q2.16 and the gain times sensitivity factor
   localparam int GAIN_W   = 18;
   localparam int FACT_W   = GAIN_W + SENS_W;
   localparam int HALF_W   = FACT_W / 2;
   localparam int PROD_W   = MAG_W + FACT_W;
   localparam int FRAC_SH  = 24;
   localparam int QOUT_W   = PROD_W - FRAC_SH;

   localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] GAIN_MED  = GAIN_W'(98304);
   localparam logic [DEN_W-1:0]  FIVE_Q8   = DEN_W'(1280);
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SENS     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_THR_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_THR_HIGH = CSR_IDX_W'(3);

   // speed band chosen from the magnitude
   typedef enum logic [1:0] {
      BAND_ONE  = 2'd0,
      BAND_MED  = 2'd1,
      BAND_HIGH = 2'd2
   } band_type;

   // data that rides along the pipeline next to the arithmetic
   typedef struct packed {
      logic signed [DELTA_W-1:0] x;
      logic signed [DELTA_W-1:0] y;
      logic                      active;
      band_type                  band;
   } side_type;

   // magnitude of a signed delta
   function automatic logic [MAG_W-1:0] pac_abs(input logic signed [DELTA_W-1:0] v);
      logic [MAG_W-1:0] e;
      e = MAG_W'(unsigned'(v));
      if (v[DELTA_W-1]) begin
         e = MAG_W'(~{v[DELTA_W-1], v}) + MAG_W'(1);
      end
      return e;
   endfunction

endpackage

// File: design/pac_req_if.sv
// movement request channel
`timescale 1ns / 1ps
interface pac_req_if;
   logic                       valid;
   logic                       ready;
   logic signed [15:0]         move_x;
   logic signed [15:0]         move_y;
   modport source (output valid, output move_x, output move_y, input ready);
   modport sink   (input valid, input move_x, input move_y, output ready);
endinterface

// File: design/pac_rsp_if.sv
// scaled movement result channel
`timescale 1ns / 1ps
interface pac_rsp_if;
   logic                       valid;
   logic                       ready;
   logic signed [15:0]         scaled_x;
   logic signed [15:0]         scaled_y;
   logic                       clipped;
   modport source (output valid, output scaled_x, output scaled_y, output clipped,
                   input ready);
   modport sink   (input valid, input scaled_x, input scaled_y, input clipped,
                   output ready);
endinterface

// File: design/pac_csr_if.sv
// register write channel
`timescale 1ns / 1ps
interface pac_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/pointer_acceleration_curve.sv
// top level: registers, squares, band select, gain, scaling and result register
`timescale 1ns / 1ps
// Scales each X/Y movement pair by a speed-dependent gain and sensitivity. One
// transaction is accepted per clock unless the pipeline holds; the result becomes valid
// after 48 register stages (input register, squares, sum, 24 square
// root stages, band select, 16 divider stages, gain, factor, partial products,
// result register). The whole pipeline
// moves as one: it holds only while the result register is full and not taken,
// so throughput is one transaction per cycle whenever the result side is ready.
// Registers may be written only while no transaction is in flight.
module pointer_acceleration_curve (
   input  logic   clock,
   input  logic   reset,
   pac_req_if.sink   req_chan,
   pac_rsp_if.source rsp_chan,
   pac_csr_if.sink   csr_chan
);
   import pac_pkg::*;

   logic              enable_ff;
   logic [SENS_W-1:0] sens_ff;
   logic [THR_W-1:0]  thr_low_ff;
   logic [THR_W-1:0]  thr_high_ff;

   logic adv;

   // register writes
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         sens_ff     <= SENS_W'(256);
         thr_low_ff  <= THR_W'(512);
         thr_high_ff <= THR_W'(2560);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_ENABLE:   enable_ff   <= csr_chan.data[0];
            REG_SENS:     sens_ff     <= csr_chan.data[SENS_W-1:0];
            REG_THR_LOW:  thr_low_ff  <= csr_chan.data[THR_W-1:0];
            REG_THR_HIGH: thr_high_ff <= csr_chan.data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   logic out_vld_ff;
   assign adv = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // input register
   logic     s1_vld_ff;
   side_type s1_side_ff, s1_side_in;
   always_comb begin
      s1_side_in.x      = req_chan.move_x;
      s1_side_in.y      = req_chan.move_y;
      s1_side_in.active = enable_ff && (req_chan.move_x != '0 || req_chan.move_y != '0);
      s1_side_in.band   = BAND_ONE;
   end

   // squares
   logic            s2_vld_ff;
   side_type        s2_side_ff;
   logic [SQ_W-1:0] xx_ff, yy_ff;

   // radicand
   logic             s3_vld_ff;
   side_type         s3_side_ff;
   logic [RAD_W-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         xx_ff      <= unsigned'(SQ_W'(s1_side_ff.x) * SQ_W'(s1_side_ff.x));
         yy_ff      <= unsigned'(SQ_W'(s1_side_ff.y) * SQ_W'(s1_side_ff.y));
         s3_side_ff <= s2_side_ff;
         rad_ff     <= {RAD_W'(xx_ff) + RAD_W'(yy_ff)} << 16;
      end
   end

   // speed
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;

   pac_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (s3_vld_ff),
      .in_rad   (rad_ff),
      .in_side  (s3_side_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // band select and divider operands
   logic             bd_vld_ff;
   side_type         bd_side_ff, bd_side_in;
   logic [DEN_W-1:0] num_ff, num_in, den_ff, den_in;
   always_comb begin
      logic [DEN_W-1:0] d;
      bd_side_in = sq_side;
      d = DEN_W'(sq_root) - DEN_W'(thr_high_ff);
      if (sq_root < thr_low_ff) begin
         bd_side_in.band = BAND_ONE;
         num_in = '0;
         den_in = DEN_W'(1);
      end else if (sq_root < thr_high_ff) begin
         bd_side_in.band = BAND_MED;
         num_in = DEN_W'(sq_root) - DEN_W'(thr_low_ff);
         den_in = DEN_W'(thr_high_ff) - DEN_W'(thr_low_ff);
      end else begin
         bd_side_in.band = BAND_HIGH;
         num_in = d;
         den_in = d + FIVE_Q8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bd_vld_ff <= 1'b0;
      end else if (adv) begin
         bd_vld_ff <= sq_vld;
      end
      if (adv) begin
         bd_side_ff <= bd_side_in;
         num_ff     <= num_in;
         den_ff     <= den_in;
      end
   end

   logic             dv_vld;
   logic [QUO_W-1:0] dv_quo;
   side_type         dv_side;

   pac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (bd_vld_ff),
      .in_num   (num_ff),
      .in_den   (den_ff),
      .in_side  (bd_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // gain, factor and partial products
   logic              gn_vld_ff, fc_vld_ff, pp_vld_ff;
   side_type          gn_side_ff, fc_side_ff, pp_side_ff;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [FACT_W-1:0] fact_ff;
   logic [PROD_W-1:0] px_lo_ff, px_hi_ff, py_lo_ff, py_hi_ff;
   logic [MAG_W-1:0]  mag_x, mag_y;

   always_comb begin
      case (dv_side.band)
         BAND_MED:  gain_in = GAIN_ONE + GAIN_W'(dv_quo >> 1);
         BAND_HIGH: gain_in = GAIN_MED + GAIN_W'(dv_quo);
         default:   gain_in = GAIN_ONE;
      endcase
   end

   assign mag_x = pac_abs(fc_side_ff.x);
   assign mag_y = pac_abs(fc_side_ff.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         gn_vld_ff <= 1'b0;
         fc_vld_ff <= 1'b0;
         pp_vld_ff <= 1'b0;
      end else if (adv) begin
         gn_vld_ff <= dv_vld;
         fc_vld_ff <= gn_vld_ff;
         pp_vld_ff <= fc_vld_ff;
      end
      if (adv) begin
         gn_side_ff <= dv_side;
         gain_ff    <= gain_in;
         fc_side_ff <= gn_side_ff;
         fact_ff    <= FACT_W'(gain_ff) * FACT_W'(sens_ff);
         pp_side_ff <= fc_side_ff;
         px_lo_ff   <= PROD_W'(mag_x) * PROD_W'(fact_ff[HALF_W-1:0]);
         px_hi_ff   <= PROD_W'(mag_x) * PROD_W'(fact_ff[FACT_W-1:HALF_W]);
         py_lo_ff   <= PROD_W'(mag_y) * PROD_W'(fact_ff[HALF_W-1:0]);
         py_hi_ff   <= PROD_W'(mag_y) * PROD_W'(fact_ff[FACT_W-1:HALF_W]);
      end
   end

   // final sum, truncation and saturation
   logic [QOUT_W-1:0]         qx, qy;
   logic signed [DELTA_W-1:0] rx, ry;
   logic                      cx, cy;
   assign qx = QOUT_W'((px_lo_ff + (px_hi_ff << HALF_W)) >> FRAC_SH);
   assign qy = QOUT_W'((py_lo_ff + (py_hi_ff << HALF_W)) >> FRAC_SH);

   always_comb begin
      cx = 1'b0;
      cy = 1'b0;
      if (pp_side_ff.x[DELTA_W-1]) begin
         if (qx > QOUT_W'(32768)) begin
            rx = DELTA_MIN;
            cx = 1'b1;
         end else begin
            rx = DELTA_W'(-qx);
         end
      end else if (qx > QOUT_W'(32767)) begin
         rx = DELTA_MAX;
         cx = 1'b1;
      end else begin
         rx = DELTA_W'(qx);
      end
      if (pp_side_ff.y[DELTA_W-1]) begin
         if (qy > QOUT_W'(32768)) begin
            ry = DELTA_MIN;
            cy = 1'b1;
         end else begin
            ry = DELTA_W'(-qy);
         end
      end else if (qy > QOUT_W'(32767)) begin
         ry = DELTA_MAX;
         cy = 1'b1;
      end else begin
         ry = DELTA_W'(qy);
      end
      if (!pp_side_ff.active) begin
         rx = pp_side_ff.x;
         ry = pp_side_ff.y;
         cx = 1'b0;
         cy = 1'b0;
      end
   end

   // result register
   logic signed [DELTA_W-1:0] out_x_ff, out_y_ff;
   logic                      out_clip_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= pp_vld_ff;
      end
      if (adv) begin
         out_x_ff    <= rx;
         out_y_ff    <= ry;
         out_clip_ff <= cx || cy;
      end
   end

   assign rsp_chan.valid    = out_vld_ff;
   assign rsp_chan.scaled_x = out_x_ff;
   assign rsp_chan.scaled_y = out_y_ff;
   assign rsp_chan.clipped  = out_clip_ff;

   // a full, untaken result register stops intake
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("intake while result stalled");

   // a clipped result sits at a rail
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_clip_ff) |-> (out_x_ff == DELTA_MAX || out_x_ff == DELTA_MIN ||
                                       out_y_ff == DELTA_MAX || out_y_ff == DELTA_MIN))
      else $error("clip flag without saturated delta");

   // a stalled pipeline keeps its result
   assert property (@(posedge clock) disable iff (reset)
      $past(out_vld_ff && !rsp_chan.ready) |-> (out_vld_ff && $stable(out_x_ff)
                                                && $stable(out_y_ff)))
      else $error("result changed during stall");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !out_vld_ff)
      else $error("result valid after reset");

endmodule

// File: design/pac_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module pac_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  logic [pac_pkg::RAD_W-1:0]   in_rad,
   input  pac_pkg::side_type           in_side,
   output logic                        out_vld,
   output logic [pac_pkg::ROOT_W-1:0]  out_root,
   output pac_pkg::side_type           out_side
);
   import pac_pkg::*;

   logic                vld_ff  [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [SQ_REM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   side_type            side_ff [ROOT_W];

   logic                vld_in  [ROOT_W];
   logic [RAD_W-1:0]    rad_in  [ROOT_W];
   logic [SQ_REM_W-1:0] rem_in  [ROOT_W];
   logic [ROOT_W-1:0]   root_in [ROOT_W];
   side_type            side_in [ROOT_W];

   // one stage: bring down two radicand bits and try the next root bit
   always_comb begin
      logic [RAD_W-1:0]    p_rad;
      logic [SQ_REM_W-1:0] p_rem;
      logic [ROOT_W-1:0]   p_root;
      logic [SQ_REM_W-1:0] r2;
      logic [SQ_REM_W-1:0] trial;
      for (int i = 0; i < ROOT_W; i++) begin
         p_rad  = (i == 0) ? in_rad : rad_ff[(i == 0) ? 0 : i - 1];
         p_rem  = (i == 0) ? '0 : rem_ff[(i == 0) ? 0 : i - 1];
         p_root = (i == 0) ? '0 : root_ff[(i == 0) ? 0 : i - 1];
         vld_in[i]  = (i == 0) ? in_vld : vld_ff[(i == 0) ? 0 : i - 1];
         side_in[i] = (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i - 1];
         r2    = {p_rem[SQ_REM_W-3:0], p_rad[RAD_W-1 -: 2]};
         trial = SQ_REM_W'({p_root, 2'b01});
         rad_in[i] = {p_rad[RAD_W-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_in[i]  = r2 - trial;
            root_in[i] = {p_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = r2;
            root_in[i] = {p_root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < ROOT_W; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_in[i];
         end
         if (adv) begin
            rad_ff[i]  <= rad_in[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

// File: design/pac_div.sv
// pipelined restoring divider, floor(num * 2^16 / den) with num < den
`timescale 1ns / 1ps
module pac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  logic [pac_pkg::DEN_W-1:0]   in_num,
   input  logic [pac_pkg::DEN_W-1:0]   in_den,
   input  pac_pkg::side_type           in_side,
   output logic                        out_vld,
   output logic [pac_pkg::QUO_W-1:0]   out_quo,
   output pac_pkg::side_type           out_side
);
   import pac_pkg::*;

   logic                 vld_ff [QUO_W];
   logic [DIV_REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0]     den_ff [QUO_W];
   logic [QUO_W-1:0]     quo_ff [QUO_W];
   side_type             side_ff[QUO_W];

   logic [DIV_REM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0]     quo_in [QUO_W];
   logic                 vld_in [QUO_W];
   logic [DEN_W-1:0]     den_in [QUO_W];
   side_type             side_in[QUO_W];

   // one stage: double the remainder and subtract the divisor if it fits
   always_comb begin
      logic [DIV_REM_W-1:0] p_rem;
      logic [QUO_W-1:0]     p_quo;
      logic [DIV_REM_W-1:0] r2;
      for (int i = 0; i < QUO_W; i++) begin
         p_rem  = (i == 0) ? DIV_REM_W'(in_num) : rem_ff[(i == 0) ? 0 : i - 1];
         p_quo  = (i == 0) ? '0 : quo_ff[(i == 0) ? 0 : i - 1];
         den_in[i]  = (i == 0) ? in_den : den_ff[(i == 0) ? 0 : i - 1];
         vld_in[i]  = (i == 0) ? in_vld : vld_ff[(i == 0) ? 0 : i - 1];
         side_in[i] = (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i - 1];
         r2 = {p_rem[DIV_REM_W-2:0], 1'b0};
         if (r2 >= DIV_REM_W'(den_in[i])) begin
            rem_in[i] = r2 - DIV_REM_W'(den_in[i]);
            quo_in[i] = {p_quo[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[i] = r2;
            quo_in[i] = {p_quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUO_W; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_in[i];
         end
         if (adv) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            den_ff[i]  <= den_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_vld  = vld_ff[QUO_W-1];
   assign out_quo  = quo_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];

endmodule

// File: sim/pac_test_ifs.sv
// note: the channel interfaces are compiled from the design folder; this file only holds test types
`timescale 1ns / 1ps
package pac_test_pkg;

   // one movement transaction and its expected scaled result
   typedef struct {
      logic signed [15:0] move_x;
      logic signed [15:0] move_y;
   } move_item;

   typedef struct {
      logic signed [15:0] scaled_x;
      logic signed [15:0] scaled_y;
      logic               clipped;
   } scaled_item;

endpackage

// File: sim/pointer_acceleration_curve_test.sv
// testbench of the pointer acceleration curve: predicted gain and scaling, random traffic
`timescale 1ns / 1ps
module pointer_acceleration_curve_test;
   import pac_pkg::*;
   import pac_test_pkg::*;

   localparam int LATENCY     = 60;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;

   pac_req_if req_chan ();
   pac_rsp_if rsp_chan ();
   pac_csr_if csr_chan ();

   pointer_acceleration_curve dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // register copies used by the predictor
   logic        curve_on;
   logic [15:0] sens_q88;
   logic [23:0] speed_low;
   logic [23:0] speed_high;

   move_item   pending_moves[$];
   scaled_item expected_scaled[$];
   int         error_count;
   int         idle_cycles;
   int         gap_left;
   int         burst_left;
   bit         hold_rsp;
   bit         long_hold;
   int         hold_count;
   bit         csr_busy;

   // clock generator
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // integer square root of a 64-bit radicand
   function automatic logic [63:0] speed_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // scale one delta by the Q.24 factor, truncate toward zero and saturate
   function automatic logic signed [15:0] scale_delta(input int delta, input logic [63:0] fact,
                                                      inout logic clip);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (delta < 0) ? 64'(-delta) : 64'(delta);
      q   = (mag * fact) >> 24;
      if (delta < 0) begin
         if (q > 64'd32768) begin
            clip = 1'b1;
            return DELTA_MIN;
         end
         return 16'(-q);
      end
      if (q > 64'd32767) begin
         clip = 1'b1;
         return DELTA_MAX;
      end
      return 16'(q);
   endfunction

   // expected scaled movement for one input pair
   function automatic scaled_item accelerate(input move_item mv);
      scaled_item  r;
      int          x;
      int          y;
      logic [63:0] m;
      logic [63:0] d;
      logic [63:0] gain;
      logic [63:0] fact;
      logic        clip;
      x = mv.move_x;
      y = mv.move_y;
      r.scaled_x = mv.move_x;
      r.scaled_y = mv.move_y;
      r.clipped  = 1'b0;
      clip = 1'b0;
      if (curve_on && (x != 0 || y != 0)) begin
         m = speed_root((64'(x * x) + 64'(y * y)) << 16);
         if (m < speed_low) begin
            gain = 64'd65536;
         end else if (m < speed_high) begin
            gain = 64'd65536 + (64'd32768 * (m - speed_low)) / (speed_high - speed_low);
         end else begin
            d    = m - speed_high;
            gain = 64'd98304 + (64'd65536 * d) / (d + 64'd1280);
         end
         fact = gain * sens_q88;
         r.scaled_x = scale_delta(x, fact, clip);
         r.scaled_y = scale_delta(y, fact, clip);
         r.clipped  = clip;
      end
      return r;
   endfunction

   // register write through the csr channel, only while idle
   task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_ENABLE:   curve_on   = val[0];
         REG_SENS:     sens_q88   = val[15:0];
         REG_THR_LOW:  speed_low  = val;
         REG_THR_HIGH: speed_high = val;
         default: ;
      endcase
   endtask

   task automatic queue_move(input logic signed [15:0] x, input logic signed [15:0] y);
      move_item mv;
      mv.move_x = x;
      mv.move_y = y;
      pending_moves.push_back(mv);
   endtask

   // wait until every transaction has come back, then let the pipe drain
   task automatic drain();
      wait (pending_moves.size() == 0 && expected_scaled.size() == 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   // random movement: half small speeds around the thresholds, half full range or at a rail
   task automatic random_moves(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: queue_move(16'($urandom), 16'($urandom));
            1: queue_move(16'($signed($urandom_range(0, 64)) - 32),
                          16'($signed($urandom_range(0, 64)) - 32));
            2: queue_move(16'($signed($urandom_range(0, 1024)) - 512), 16'sd0);
            default: queue_move(16'($urandom_range(0, 1) ? -32768 : 32767),
                                16'($urandom));
         endcase
      end
   endtask

   // stimulus in phases with register settings between them
   initial begin
      error_count = 0;
      csr_busy = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      curve_on   = 1'b1;
      sens_q88   = 16'd256;
      speed_low  = 24'd512;
      speed_high = 24'd2560;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (LATENCY) @(posedge clock);
      write_reg(REG_ENABLE, 24'd1);
      write_reg(REG_SENS, 24'd256);
      write_reg(REG_THR_LOW, 24'd512);
      write_reg(REG_THR_HIGH, 24'd2560);
      write_reg(8'd9, 24'hFFFFFF);
      csr_busy = 1'b0;

      // directed: no movement, field extremes, bands
      queue_move(16'sd0, 16'sd0);
      queue_move(16'sd1, 16'sd0);
      queue_move(-16'sd1, 16'sd1);
      queue_move(16'sd5, 16'sd0);
      queue_move(16'sd30, -16'sd40);
      queue_move(16'sd32767, 16'sd0);
      queue_move(-16'sd32768, 16'sd0);
      queue_move(-16'sd32768, -16'sd32768);
      queue_move(16'sd32767, 16'sd32767);
      queue_move(16'sd0, -16'sd3);
      queue_move(16'sd10, 16'sd0);
      queue_move(16'sd2, 16'sd0);
      random_moves(300);
      drain();

      // bypass with extremes
      csr_busy = 1'b1;
      write_reg(REG_ENABLE, 24'd0);
      csr_busy = 1'b0;
      queue_move(-16'sd32768, 16'sd32767);
      queue_move(16'sd0, 16'sd0);
      random_moves(200);
      drain();

      // zero sensitivity, reversed thresholds
      csr_busy = 1'b1;
      write_reg(REG_ENABLE, 24'd1);
      write_reg(REG_SENS, 24'd0);
      write_reg(REG_THR_LOW, 24'd3000);
      write_reg(REG_THR_HIGH, 24'd100);
      csr_busy = 1'b0;
      random_moves(250);
      drain();

      // maximum sensitivity, maximum thresholds
      csr_busy = 1'b1;
      write_reg(REG_SENS, 24'hFFFF);
      write_reg(REG_THR_LOW, 24'hFFFFFF);
      write_reg(REG_THR_HIGH, 24'hFFFFFF);
      csr_busy = 1'b0;
      random_moves(250);
      drain();

      // equal thresholds at zero, everything in the high band
      csr_busy = 1'b1;
      write_reg(REG_SENS, 24'd300);
      write_reg(REG_THR_LOW, 24'd0);
      write_reg(REG_THR_HIGH, 24'd0);
      csr_busy = 1'b0;
      random_moves(250);
      drain();

      // random settings
      for (int p = 0; p < 3; p++) begin
         csr_busy = 1'b1;
         write_reg(REG_SENS, 24'($urandom_range(0, 1024)));
         write_reg(REG_THR_LOW, 24'($urandom_range(0, 20000)));
         write_reg(REG_THR_HIGH, 24'($urandom_range(0, 40000)));
         csr_busy = 1'b0;
         random_moves(200);
         drain();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // driver: bursts of transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid  <= 1'b0;
         req_chan.move_x <= '0;
         req_chan.move_y <= '0;
         gap_left   <= 0;
         burst_left <= 0;
      end else begin
         automatic bit done_item = req_chan.valid && req_chan.ready;
         if (done_item) expected_scaled.push_back(accelerate(pending_moves.pop_front()));
         if (gap_left > 0 && (!req_chan.valid || done_item)) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (!req_chan.valid || done_item) begin
            if (pending_moves.size() > 0 && !csr_busy) begin
               req_chan.valid  <= 1'b1;
               req_chan.move_x <= pending_moves[0].move_x;
               req_chan.move_y <= pending_moves[0].move_y;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
               end else if (burst_left == 1) begin
                  burst_left <= 0;
                  if ($urandom_range(0, 1)) gap_left <= $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off while traffic keeps coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_rsp   <= 1'b0;
         long_hold  <= 1'b0;
         hold_count <= 0;
      end else if (!long_hold && expected_scaled.size() > 20) begin
         long_hold      <= 1'b1;
         hold_count     <= 300;
         rsp_chan.ready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count     <= hold_count - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 15) == 0) hold_rsp <= ~hold_rsp;
         rsp_chan.ready <= hold_rsp ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_scaled.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d clipped=%0b", $time,
                     rsp_chan.scaled_x, rsp_chan.scaled_y, rsp_chan.clipped);
            error_count <= error_count + 1;
         end else begin
            automatic scaled_item e = expected_scaled.pop_front();
            if (e.scaled_x !== rsp_chan.scaled_x || e.scaled_y !== rsp_chan.scaled_y
                || e.clipped !== rsp_chan.clipped) begin
               $display("%0t: mismatch exp x=%0d y=%0d c=%0b act x=%0d y=%0d c=%0b",
                        $time, e.scaled_x, e.scaled_y, e.clipped,
                        rsp_chan.scaled_x, rsp_chan.scaled_y, rsp_chan.clipped);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
design/pac_pkg.sv
design/pac_req_if.sv
design/pac_rsp_if.sv
design/pac_csr_if.sv
design/pac_sqrt.sv
design/pac_div.sv
design/pointer_acceleration_curve.sv
sim/pac_test_ifs.sv
sim/pointer_acceleration_curve_test.sv
